>>> hdl/d2c_pkg.sv
// Package for the depth-to-color registration block.
// Holds sizes, arithmetic widths, register and opcode codes and reset values.
// No dependencies; every other file of the block uses it.
package d2c_pkg;

  // Color frame store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int QW         = (COL_W > ROW_W) ? COL_W : ROW_W;

  // Field widths
  localparam int RGB_W   = 24;
  localparam int MM_W    = 16;
  localparam int CODE_W  = 16;
  localparam int WID_W   = 11;
  localparam int HGT_W   = 10;
  localparam int LIM_W   = WID_W;
  localparam int CFG_W   = 64;
  localparam int PADDR_W = 6;

  // Datapath widths, sized for the worst case of every product and sum
  localparam int EX_W   = CODE_W + 2;
  localparam int PF_W   = EX_W + CODE_W + 1;
  localparam int M_W    = CODE_W + PF_W;
  localparam int BR_W   = M_W + 2;
  localparam int FF_W   = 2 * CODE_W;
  localparam int TF_W   = FF_W + 10;
  localparam int TR_W   = CODE_W + TF_W + 1;
  localparam int BM_W   = BR_W + MM_W + 1;
  localparam int N_W    = BM_W + 1;
  localparam int NF_W   = N_W + CODE_W + 1;
  localparam int NC_W   = N_W + CODE_W + 2;
  localparam int NUM_W  = NC_W + 1;
  localparam int DEN_W  = N_W + 4;
  localparam int DL_W   = N_W + LIM_W + 1 + 4;
  localparam int REM_W  = NUM_W;

  // Pipeline shape: six transform stages, then projection and division
  localparam int PROJ_ST = 3 + QW;
  localparam int NPIPE   = 6 + PROJ_ST;
  localparam int OUT_ST  = NPIPE + 1;

  // Millimetres per metre, and one half pixel in Q12.4
  localparam logic [9:0]  MM_PER_M  = 10'd1000;
  localparam logic [17:0] HALF_PIX  = 18'd8;

  // Configuration reset values
  localparam logic [CFG_W-1:0] POSE_X_RST = 64'h1000_0000_0000_0000;
  localparam logic [CFG_W-1:0] POSE_Y_RST = 64'h0000_1000_0000_0000;
  localparam logic [CFG_W-1:0] POSE_Z_RST = 64'h0000_0000_1000_0000;
  localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 10'd480;

  // Register indexes
  typedef enum logic [2:0] {
    REG_DEPTH_INTR = 3'd0,
    REG_COLOR_INTR = 3'd1,
    REG_POSE_X     = 3'd2,
    REG_POSE_Y     = 3'd3,
    REG_POSE_Z     = 3'd4,
    REG_COLOR_W    = 3'd5,
    REG_COLOR_H    = 3'd6
  } reg_idx_t;

  // Opcodes
  typedef enum logic {
    OP_COLOR = 1'b0,
    OP_DEPTH = 1'b1
  } opcode_t;

  // Side information that travels with each word down the pipeline
  typedef struct packed {
    opcode_t          op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [RGB_W-1:0] rgb;
    logic             good;
  } side_t;

endpackage

>>> hdl/d2c_in_if.sv
// Input channel of the registration block: valid/ready plus one input word.
// Depends on d2c_pkg for field widths.
interface d2c_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [d2c_pkg::COL_W-1:0] pixel_col;
  logic [d2c_pkg::ROW_W-1:0] pixel_row;
  logic [d2c_pkg::MM_W-1:0]  depth_mm;
  logic                      depth_valid;
  logic [d2c_pkg::RGB_W-1:0] color_in;

  modport source (output valid, opcode, pixel_col, pixel_row, depth_mm, depth_valid,
                  color_in, input ready);
  modport sink (input valid, opcode, pixel_col, pixel_row, depth_mm, depth_valid,
                color_in, output ready);
endinterface

>>> hdl/d2c_out_if.sv
// Result channel of the registration block: valid/ready plus one result word.
// Depends on d2c_pkg for field widths.
interface d2c_out_if;
  logic                      valid;
  logic                      ready;
  logic [d2c_pkg::COL_W-1:0] out_col;
  logic [d2c_pkg::ROW_W-1:0] out_row;
  logic [d2c_pkg::RGB_W-1:0] color_out;
  logic                      hit;

  modport source (output valid, out_col, out_row, color_out, hit, input ready);
  modport sink (input valid, out_col, out_row, color_out, hit, output ready);
endinterface

>>> hdl/d2c_proj.sv
// One axis of the color-camera projection: scales the point, adds the principal
// point and half a pixel, range-checks, then divides by z one quotient bit a stage.
// Depends on d2c_pkg.
module d2c_proj (
  input  logic                               clk,
  input  logic [d2c_pkg::PROJ_ST-1:0]        en,
  input  logic signed [d2c_pkg::N_W-1:0]     n_i,
  input  logic signed [d2c_pkg::N_W-1:0]     nz_i,
  input  logic [d2c_pkg::CODE_W-1:0]         f_i,
  input  logic [d2c_pkg::CODE_W-1:0]         c_i,
  input  logic [d2c_pkg::LIM_W-1:0]          lim_i,
  output logic [d2c_pkg::QW-1:0]             q_o,
  output logic                               ok_o
);
  import d2c_pkg::*;

  logic signed [NF_W-1:0]        nf_r;
  logic signed [NC_W-1:0]        nc_r;
  logic signed [N_W-1:0]         nza_r;
  logic signed [N_W-1:0]         nzb_r;
  logic signed [NUM_W-1:0]       num_r;
  logic signed [DL_W-1:0]        dl_r;
  logic [17:0]                   c8;
  logic signed [N_W+LIM_W:0]     nzl;
  logic signed [DEN_W-1:0]       den16;
  logic signed [NUM_W:0]         upper;
  logic                          ok_c;
  logic [REM_W-1:0]              rem_r [0:QW];
  logic [DEN_W-1:0]              dv_r  [0:QW];
  logic [QW-1:0]                 q_r   [0:QW];
  logic                          okr_r [0:QW];
  logic [REM_W-1:0]              t_c   [1:QW];

  // Principal point plus half a pixel, and the range bound z*16*lim
  always_comb begin
    c8    = {2'b00, c_i} + HALF_PIX;
    nzl   = nza_r * $signed({1'b0, lim_i});
    den16 = {nzb_r, 4'b0000};
    upper = (NUM_W + 1)'(num_r) + (NUM_W + 1)'(den16);
    ok_c  = (lim_i != '0) && (upper > 0) && (num_r < dl_r);
  end

  // Products of the numerator terms
  always_ff @(posedge clk) begin
    if (en[0]) begin
      nf_r  <= n_i * $signed({1'b0, f_i});
      nc_r  <= nz_i * $signed(c8);
      nza_r <= nz_i;
    end
  end

  // Numerator sum and range bound
  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_r <= NUM_W'(nf_r) + NUM_W'(nc_r);
      dl_r  <= {nzl, 4'b0000};
      nzb_r <= nza_r;
    end
  end

  // Range check; a numerator at or below zero truncates to index zero
  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_r[0] <= (num_r > 0) ? REM_W'(num_r) : '0;
      dv_r[0]  <= den16;
      q_r[0]   <= '0;
      okr_r[0] <= ok_c;
    end
  end

  // Restoring division, most significant quotient bit first
  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      t_c[k] = REM_W'(dv_r[k-1]) << (QW - k);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= QW; k++) begin
      if (en[2+k]) begin
        dv_r[k]  <= dv_r[k-1];
        okr_r[k] <= okr_r[k-1];
        if (rem_r[k-1] >= t_c[k]) begin
          rem_r[k] <= rem_r[k-1] - t_c[k];
          q_r[k]   <= q_r[k-1] | (QW'(1) << (QW - k));
        end else begin
          rem_r[k] <= rem_r[k-1];
          q_r[k]   <= q_r[k-1];
        end
      end
    end
  end

  assign q_o  = q_r[QW];
  assign ok_o = okr_r[QW];

endmodule

>>> hdl/depth_to_color_registration_top.sv
// Depth-to-color registration: a 20-stage pipeline around one color frame store.
// Depends on d2c_pkg, d2c_in_if, d2c_out_if and d2c_proj.
//
// The block takes one word per clock while the result side does not stall; a depth
// word's result passes every stage and then the output register. Colour writes travel
// down the same pipeline and touch the frame store at the final stage, so reads
// and writes happen strictly in arrival order through a single-port 512K x 24
// memory, one access per word. The store is not cleared at reset: a pixel must
// be written before a depth word can land on it. Configuration registers are
// 64-bit APB registers at byte addresses 8*i and may be changed only while the
// pipeline is empty.
module depth_to_color_registration_top (
  input  logic                         clk,
  input  logic                         rst_n,
  d2c_in_if.sink                       in_chan,
  d2c_out_if.source                    out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [d2c_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [d2c_pkg::CFG_W-1:0]    cfg_pwdata,
  output logic [d2c_pkg::CFG_W-1:0]    cfg_prdata,
  output logic                         cfg_pready
);
  import d2c_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] dintr_r;
  logic [CFG_W-1:0] cintr_r;
  logic [CFG_W-1:0] pose_r [0:2];
  logic [WID_W-1:0] cwid_r;
  logic [HGT_W-1:0] chgt_r;
  reg_idx_t         idx;
  logic             cfg_wr;

  // Pipeline control
  logic [NPIPE:1]   v_r;
  logic [OUT_ST:1]  en;
  side_t            sb_r [1:NPIPE];
  side_t            sb_in;

  // Transform stages
  logic signed [EX_W-1:0] ex1_r, ey1_r;
  logic [FF_W-1:0]        ff1_r, ff2_r;
  logic [TF_W-1:0]        tf2_r;
  logic signed [PF_W-1:0] exfy_r, eyfx_r;
  logic signed [M_W-1:0]  m0_r [0:2];
  logic signed [M_W-1:0]  m1_r [0:2];
  logic signed [M_W-1:0]  m2_r [0:2];
  logic signed [TR_W-1:0] tr3_r [0:2];
  logic signed [TR_W-1:0] tr4_r [0:2];
  logic signed [TR_W-1:0] tr5_r [0:2];
  logic signed [BR_W-1:0] br_r [0:2];
  logic signed [BM_W-1:0] bm_r [0:2];
  logic signed [N_W-1:0]  n_r  [0:2];
  logic [MM_W-1:0]        mm1_r, mm2_r, mm3_r, mm4_r;

  // Projection and output
  logic [LIM_W-1:0]  limw, limh;
  logic [QW-1:0]     qx, qy;
  logic              okx, oky;
  logic              nz_pos;
  logic              vo_r;
  opcode_t           opo_r;
  logic [COL_W-1:0]  colo_r;
  logic [ROW_W-1:0]  rowo_r;
  logic              hito_r;
  logic [RGB_W-1:0]  rd_r;
  logic [RGB_W-1:0]  store [0:(1 << ADDR_W)-1];

  // Register file write and read
  assign idx        = reg_idx_t'(cfg_paddr[PADDR_W-1:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dintr_r   <= '0;
      cintr_r   <= '0;
      pose_r[0] <= POSE_X_RST;
      pose_r[1] <= POSE_Y_RST;
      pose_r[2] <= POSE_Z_RST;
      cwid_r    <= WIDTH_RST;
      chgt_r    <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_DEPTH_INTR: dintr_r   <= cfg_pwdata;
        REG_COLOR_INTR: cintr_r   <= cfg_pwdata;
        REG_POSE_X:     pose_r[0] <= cfg_pwdata;
        REG_POSE_Y:     pose_r[1] <= cfg_pwdata;
        REG_POSE_Z:     pose_r[2] <= cfg_pwdata;
        REG_COLOR_W:    cwid_r    <= cfg_pwdata[WID_W-1:0];
        REG_COLOR_H:    chgt_r    <= cfg_pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEPTH_INTR: cfg_prdata = dintr_r;
      REG_COLOR_INTR: cfg_prdata = cintr_r;
      REG_POSE_X:     cfg_prdata = pose_r[0];
      REG_POSE_Y:     cfg_prdata = pose_r[1];
      REG_POSE_Z:     cfg_prdata = pose_r[2];
      REG_COLOR_W:    cfg_prdata = CFG_W'(cwid_r);
      REG_COLOR_H:    cfg_prdata = CFG_W'(chgt_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Stage enables: a stage loads when it is empty or its successor moves on
  always_comb begin
    en[OUT_ST] = !out_chan.valid || out_chan.ready;
    for (int k = NPIPE; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_chan.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NPIPE; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 1) ? in_chan.valid : v_r[k-1];
        end
      end
    end
  end

  // Side information; a zero focal length or invalid depth clears good up front
  always_comb begin
    sb_in.op   = opcode_t'(in_chan.opcode);
    sb_in.col  = in_chan.pixel_col;
    sb_in.row  = in_chan.pixel_row;
    sb_in.rgb  = in_chan.color_in;
    sb_in.good = in_chan.depth_valid &&
                 (dintr_r[63:48] != '0) && (dintr_r[47:32] != '0) &&
                 (cintr_r[63:48] != '0) && (cintr_r[47:32] != '0);
  end

  assign nz_pos = n_r[2] > 0;

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NPIPE; k++) begin
      if (en[k]) begin
        if (k == 1) begin
          sb_r[k] <= sb_in;
        end else begin
          sb_r[k] <= sb_r[k-1];
        end
        if (k == 7) begin
          sb_r[k].good <= sb_r[k-1].good && nz_pos;
        end
      end
    end
  end

  // Stage 1: offsets from the depth principal point, and fx*fy
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ex1_r <= $signed({{(EX_W-COL_W-4){1'b0}}, in_chan.pixel_col, 4'b0000}) -
               $signed({2'b00, dintr_r[31:16]});
      ey1_r <= $signed({{(EX_W-ROW_W-4){1'b0}}, in_chan.pixel_row, 4'b0000}) -
               $signed({2'b00, dintr_r[15:0]});
      ff1_r <= dintr_r[63:48] * dintr_r[47:32];
      mm1_r <= in_chan.depth_mm;
    end
  end

  // Stage 2: cross-scale the offsets by the other focal length
  always_ff @(posedge clk) begin
    if (en[2]) begin
      exfy_r <= ex1_r * $signed({1'b0, dintr_r[47:32]});
      eyfx_r <= ey1_r * $signed({1'b0, dintr_r[63:48]});
      ff2_r  <= ff1_r;
      tf2_r  <= ff1_r * MM_PER_M;
      mm2_r  <= mm1_r;
    end
  end

  // Stage 3: pose terms for all three rows
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        m0_r[j]  <= $signed(pose_r[j][63:48]) * exfy_r;
        m1_r[j]  <= $signed(pose_r[j][47:32]) * eyfx_r;
        m2_r[j]  <= $signed(pose_r[j][31:16]) * $signed({1'b0, ff2_r});
        tr3_r[j] <= $signed(pose_r[j][15:0]) * $signed({1'b0, tf2_r});
      end
      mm3_r <= mm2_r;
    end
  end

  // Stage 4: rotation sum
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int j = 0; j < 3; j++) begin
        br_r[j]  <= BR_W'(m0_r[j]) + BR_W'(m1_r[j]) + BR_W'(m2_r[j]);
        tr4_r[j] <= tr3_r[j];
      end
      mm4_r <= mm3_r;
    end
  end

  // Stage 5: scale by depth
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int j = 0; j < 3; j++) begin
        bm_r[j]  <= br_r[j] * $signed({1'b0, mm4_r});
        tr5_r[j] <= tr4_r[j];
      end
    end
  end

  // Stage 6: add translation
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 3; j++) begin
        n_r[j] <= N_W'(bm_r[j]) + N_W'(tr5_r[j]);
      end
    end
  end

  // Frame limits clipped to the store size
  assign limw = (cwid_r < LIM_W'(MAX_WIDTH)) ? cwid_r : LIM_W'(MAX_WIDTH);
  assign limh = (chgt_r < HGT_W'(MAX_HEIGHT)) ? LIM_W'(chgt_r) : LIM_W'(MAX_HEIGHT);

  // Stages 7 to 19: projection and division per axis
  d2c_proj u_proj_x (
    .clk   (clk),
    .en    (en[NPIPE:7]),
    .n_i   (n_r[0]),
    .nz_i  (n_r[2]),
    .f_i   (cintr_r[63:48]),
    .c_i   (cintr_r[31:16]),
    .lim_i (limw),
    .q_o   (qx),
    .ok_o  (okx)
  );

  d2c_proj u_proj_y (
    .clk   (clk),
    .en    (en[NPIPE:7]),
    .n_i   (n_r[1]),
    .nz_i  (n_r[2]),
    .f_i   (cintr_r[47:32]),
    .c_i   (cintr_r[15:0]),
    .lim_i (limh),
    .q_o   (qy),
    .ok_o  (oky)
  );

  // Frame store: a color word writes, a depth word reads, in arrival order
  always_ff @(posedge clk) begin
    if (en[OUT_ST] && v_r[NPIPE]) begin
      if (sb_r[NPIPE].op == OP_COLOR) begin
        store[{sb_r[NPIPE].row, sb_r[NPIPE].col}] <= sb_r[NPIPE].rgb;
      end else begin
        rd_r <= store[{qy[ROW_W-1:0], qx[COL_W-1:0]}];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en[OUT_ST]) begin
      vo_r <= v_r[NPIPE];
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUT_ST]) begin
      opo_r  <= sb_r[NPIPE].op;
      colo_r <= sb_r[NPIPE].col;
      rowo_r <= sb_r[NPIPE].row;
      hito_r <= sb_r[NPIPE].good && okx && oky;
    end
  end

  assign out_chan.valid     = vo_r && (opo_r == OP_DEPTH);
  assign out_chan.out_col   = colo_r;
  assign out_chan.out_row   = rowo_r;
  assign out_chan.hit       = hito_r;
  assign out_chan.color_out = hito_r ? rd_r : '0;

endmodule

>>> hdl/d2c_checker.sv
// Port-level checks for the registration block, bound to its top level.
// Depends on d2c_pkg and on the top level's channel interfaces.
module d2c_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_hit,
  input logic [d2c_pkg::RGB_W-1:0] out_color,
  input logic [d2c_pkg::COL_W-1:0] out_col,
  input logic [d2c_pkg::ROW_W-1:0] out_row
);
  import d2c_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color) &&
                               $stable(out_col) && $stable(out_row) && $stable(out_hit))
    else $error("result word changed while stalled");

  // A miss never carries a color.
  a_miss_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_color == '0)
    else $error("miss with nonzero color");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the result side free, the pipeline never refuses a word.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while result side is free");

endmodule

bind depth_to_color_registration_top d2c_checker u_d2c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_hit   (out_chan.hit),
  .out_color (out_chan.color_out),
  .out_col   (out_chan.out_col),
  .out_row   (out_chan.out_row)
);
